@@ rtl/erp_pkg.sv @@
// Shared types, record codes and helpers for the event record stream parser.
// No dependencies; every module in rtl/ imports this package.
package erp_pkg;

  // Record codes that need special handling
  localparam logic [4:0] C_DUAL_PRESS = 5'h03;
  localparam logic [4:0] C_APNEA_A    = 5'h05;
  localparam logic [4:0] C_APNEA_B    = 5'h06;
  localparam logic [4:0] C_APNEA_C    = 5'h07;
  localparam logic [7:0] C_RSVD_A     = 8'h08;
  localparam logic [7:0] C_RSVD_B     = 8'h09;
  localparam logic [4:0] C_APNEA_D    = 5'h0a;
  localparam logic [4:0] C_PAIR       = 5'h0b;
  localparam logic [4:0] C_APNEA_E    = 5'h0c;
  localparam logic [4:0] C_BARE       = 5'h0d;
  localparam logic [4:0] C_TRIPLE_A   = 5'h0e;
  localparam logic [4:0] C_WORD_OFS   = 5'h0f;
  localparam logic [4:0] C_TRIPLE_B   = 5'h10;
  localparam logic [4:0] C_DUAL_LEAK  = 5'h11;
  localparam logic [4:0] C_NO_DELTA   = 5'h12;
  localparam logic [7:0] C_MAX_CODE   = 8'h12;

  // Kinds of the second event of a two-event record
  localparam logic [4:0] KIND_SNORE2  = 5'd19;
  localparam logic [4:0] KIND_PRESS2  = 5'd20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } erp_in_t;

  typedef struct packed {
    logic [4:0]  event_kind;
    logic [31:0] event_time;
    logic [15:0] value_a;
    logic [7:0]  value_b;
    logic [15:0] value_c;
    logic [1:0]  value_count;
    logic        parse_error;
    logic        last_result;
  } erp_out_t;

  // Results caused by one byte: zero, one or two
  typedef struct packed {
    logic [1:0] count;
    erp_out_t   first;
    erp_out_t   second;
  } erp_pair_t;

  // Payload length in bytes for a known code
  function automatic logic [2:0] payload_len(input logic [4:0] code);
    logic [2:0] len;
    begin
      unique case (code) inside
        C_DUAL_PRESS, C_PAIR, C_DUAL_LEAK: len = 3'd2;
        C_BARE:                            len = 3'd0;
        C_TRIPLE_A, C_WORD_OFS, C_TRIPLE_B: len = 3'd3;
        C_NO_DELTA:                        len = 3'd4;
        default:                           len = 3'd1;
      endcase
      return len;
    end
  endfunction

  function automatic erp_out_t error_result();
    erp_out_t r;
    begin
      r             = '0;
      r.parse_error = 1'b1;
      r.last_result = 1'b1;
      return r;
    end
  endfunction

endpackage

@@ rtl/event_record_stream_parser.sv @@
// Event record stream parser, top level. Depends on erp_pkg, erp_parse, erp_outq.
// A result is registered in the 4-entry result queue when the byte that
// completes its record is transferred. Throughput: one byte per cycle while
// in_stall is low; the queue absorbs the second event of a two-event record.
// Reset (rst, synchronous, active high): parser expects a code byte, base time 0,
// result queue empty.
module event_record_stream_parser import erp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  erp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output erp_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic      accept;
  logic      q_full;
  erp_pair_t results;

  // Stall the source only when the queue cannot take a full record's events;
  // a waiting result on the output side does not block new bytes otherwise.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Parse one byte per transfer; results appear combinationally from the
  // parser state plus the incoming byte and are registered in the queue.
  erp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .results     (results)
  );

  // Serialize zero, one or two results per byte onto the output channel.
  erp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .results   (results),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/erp_parse.sv @@
// Record parser core: phase tracking, delta accumulation, payload capture
// and event formatting for one byte per cycle while accept is high. Depends on erp_pkg.
module erp_parse import erp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  erp_in_t     in_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output erp_pair_t   results
);

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_DLO  = 2'd1;
  localparam logic [1:0] PH_DHI  = 2'd2;
  localparam logic [1:0] PH_PAY  = 2'd3;

  logic [31:0] base_time;
  logic [1:0]  phase, phase_next;
  logic [4:0]  code, code_next;
  logic [7:0]  delta_low, delta_low_next;
  logic [2:0]  pidx, pidx_next;
  logic [31:0] running_time, running_time_next;
  logic        halted, halted_next;
  logic        started, started_next;
  logic [7:0]  payload [4];

  logic [7:0]  b;
  logic        last;
  logic        done;
  logic        pay_wr;
  logic [31:0] rt_cur;
  logic [7:0]  p0, p1, p2, p3;
  erp_out_t    ev0, ev1;
  logic [1:0]  ev_cnt;

  assign b      = in_data.data_byte;
  assign last   = in_data.last_byte;
  assign rt_cur = started ? running_time : base_time;
  assign pay_wr = !halted && (phase == PH_PAY);

  // Payload view including the byte arriving now
  assign p0 = (pay_wr && pidx[1:0] == 2'd0) ? b : payload[0];
  assign p1 = (pay_wr && pidx[1:0] == 2'd1) ? b : payload[1];
  assign p2 = (pay_wr && pidx[1:0] == 2'd2) ? b : payload[2];
  assign p3 = (pay_wr && pidx[1:0] == 2'd3) ? b : payload[3];

  always_comb begin
    phase_next        = phase;
    code_next         = code;
    delta_low_next    = delta_low;
    pidx_next         = pidx;
    running_time_next = rt_cur;
    halted_next       = halted;
    started_next      = 1'b1;
    done              = 1'b0;
    results           = '0;

    if (halted) begin
      // drop bytes until the stream ends
      if (last) begin
        halted_next  = 1'b0;
        started_next = 1'b0;
        phase_next   = PH_CODE;
        pidx_next    = 3'd0;
      end
    end else begin
      unique case (phase)
        PH_CODE: begin
          if (b > C_MAX_CODE || b == C_RSVD_A || b == C_RSVD_B) begin
            results.count = 2'd1;
            results.first = error_result();
            if (last) begin
              started_next = 1'b0;
            end else begin
              halted_next = 1'b1;
            end
          end else begin
            code_next  = b[4:0];
            pidx_next  = 3'd0;
            phase_next = (b[4:0] == C_NO_DELTA) ? PH_PAY : PH_DLO;
          end
        end
        PH_DLO: begin
          delta_low_next = b;
          phase_next     = PH_DHI;
        end
        PH_DHI: begin
          running_time_next = rt_cur + {{16{b[7]}}, b, delta_low};
          phase_next        = PH_PAY;
          done              = (payload_len(code) == 3'd0);
        end
        PH_PAY: begin
          pidx_next = pidx + 3'd1;
          done      = (pidx + 3'd1) >= payload_len(code);
        end
        default: begin
          phase_next = PH_CODE;
        end
      endcase

      if (done) begin
        results.count  = ev_cnt;
        results.first  = ev0;
        results.second = ev1;
        phase_next     = PH_CODE;
        pidx_next      = 3'd0;
        if (last) begin
          started_next = 1'b0;
        end
      end else if (last && results.count == 2'd0) begin
        // record cut short by the end of the stream
        results.count = 2'd1;
        results.first = error_result();
        phase_next    = PH_CODE;
        pidx_next     = 3'd0;
        started_next  = 1'b0;
      end
    end
  end

  // Event formatting for a completed record
  always_comb begin
    ev0            = '0;
    ev1            = '0;
    ev_cnt         = 2'd1;
    ev0.event_kind = code;
    ev0.event_time = running_time_next;
    ev1.event_time = running_time_next;
    unique case (code) inside
      C_DUAL_PRESS: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_b     = p1;
        ev0.value_count = 2'd2;
        ev1.event_kind  = KIND_PRESS2;
        ev1.value_a     = {8'd0, p1};
        ev1.value_count = 2'd1;
        ev_cnt          = 2'd2;
      end
      C_APNEA_A, C_APNEA_B, C_APNEA_C, C_APNEA_D, C_APNEA_E: begin
        ev0.event_time = running_time_next - {24'd0, p0};
      end
      C_PAIR: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_b     = p1;
        ev0.value_count = 2'd2;
      end
      C_BARE: begin
        ev0.value_count = 2'd0;
      end
      C_TRIPLE_A, C_TRIPLE_B: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_b     = p1;
        ev0.value_c     = {8'd0, p2};
        ev0.value_count = 2'd3;
      end
      C_WORD_OFS: begin
        ev0.event_time  = running_time_next - {24'd0, p2};
        ev0.value_a     = {p1, p0};
        ev0.value_b     = p2;
        ev0.value_count = 2'd2;
      end
      C_DUAL_LEAK: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_count = 2'd1;
        ev1.event_kind  = KIND_SNORE2;
        ev1.value_a     = {8'd0, p1};
        ev1.value_count = 2'd1;
        ev_cnt          = (p1 != 8'd0) ? 2'd2 : 2'd1;
      end
      C_NO_DELTA: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_b     = p1;
        ev0.value_c     = {p3, p2};
        ev0.value_count = 2'd3;
      end
      default: begin
        ev0.value_a     = {8'd0, p0};
        ev0.value_count = 2'd1;
      end
    endcase
    // mark the final event of the record
    if (ev_cnt == 2'd2) begin
      ev1.last_result = 1'b1;
    end else begin
      ev0.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time    <= '0;
      phase        <= PH_CODE;
      code         <= '0;
      delta_low    <= '0;
      pidx         <= '0;
      running_time <= '0;
      halted       <= 1'b0;
      started      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_time <= cfg_wr_data;
      end
      if (accept) begin
        phase        <= phase_next;
        code         <= code_next;
        delta_low    <= delta_low_next;
        pidx         <= pidx_next;
        running_time <= running_time_next;
        halted       <= halted_next;
        started      <= started_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pay_wr) begin
      payload[pidx[1:0]] <= b;
    end
  end

endmodule

@@ rtl/erp_outq.sv @@
// Four-entry result queue: takes up to two results per cycle, drives one
// registered result per unstalled cycle to the sink. Depends on erp_pkg.
module erp_outq import erp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  erp_pair_t results,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output erp_out_t  out_data
);

  erp_out_t   q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] cnt, cnt_next;
  logic       pop;
  logic [1:0] n_push;

  assign out_valid = (cnt != 3'd0);
  assign out_data  = q[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // hold off the source unless room remains for a two-event record
  assign full      = (cnt > 3'd2);
  assign n_push    = push ? results.count : 2'd0;
  assign cnt_next  = cnt + {1'b0, n_push} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      cnt    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q[wr_ptr] <= results.first;
    end
    if (n_push == 2'd2) begin
      q[wr_ptr + 2'd1] <= results.second;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for event_record_stream_parser: random event streams
// with bursty input and receiver stalls, checked against a parser model here.
// Depends on rtl/erp_pkg.sv and the parser RTL.
module tb_top;
  import erp_pkg::*;

  // Parse phases of the bench's own parser model
  typedef enum logic [1:0] {
    EXPECT_CODE,
    EXPECT_DELTA_LO,
    EXPECT_DELTA_HI,
    EXPECT_PAYLOAD
  } parse_phase_t;

  localparam int ITEMS_PER_PHASE = 340;
  localparam int TAIL_CYCLES     = 4;
  localparam logic [31:0] BASE_SETTINGS [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FF00
  };

  // Directed opening: a bare record, extreme deltas, a leak record
  // with a zero second byte, an unknown code with ignored trailing bytes, an
  // unknown code on the last byte, and a record cut short after its delta.
  localparam erp_in_t DIRECTED [31] = '{
    '{8'h0d, 1'b0}, '{8'h00, 1'b0}, '{8'h80, 1'b0},
    '{8'h03, 1'b0}, '{8'hff, 1'b0}, '{8'h7f, 1'b0}, '{8'hff, 1'b0}, '{8'h00, 1'b0},
    '{8'h11, 1'b0}, '{8'h01, 1'b0}, '{8'h00, 1'b0}, '{8'h12, 1'b0}, '{8'h00, 1'b0},
    '{8'h12, 1'b0}, '{8'hff, 1'b0}, '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'hff, 1'b0},
    '{8'h0f, 1'b0}, '{8'hff, 1'b0}, '{8'hff, 1'b0}, '{8'h34, 1'b0}, '{8'h12, 1'b0},
    '{8'hff, 1'b1},
    '{8'h14, 1'b0}, '{8'haa, 1'b0}, '{8'h55, 1'b1},
    '{8'h09, 1'b1},
    '{8'h05, 1'b0}, '{8'h10, 1'b0}, '{8'hff, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  erp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  erp_out_t    out_data;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  event_record_stream_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bytes waiting to be driven, and events the model says must come out
  erp_in_t  pending_bytes [$];
  erp_out_t expected_events [$];
  int       errors = 0;
  int       bytes_queued = 0;

  // Parser model state
  logic [31:0]  base_time_q;
  parse_phase_t phase_q;
  logic [4:0]   code_q;
  logic [7:0]   delta_lo_q;
  logic [7:0]   payload_q [4];
  logic [2:0]   pay_idx_q;
  logic [31:0]  clock_q;
  logic         halted_q;
  logic         stream_open_q;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic int record_len(input logic [4:0] code);
    case (code)
      C_DUAL_PRESS, C_PAIR, C_DUAL_LEAK:   return 2;
      C_BARE:                              return 0;
      C_TRIPLE_A, C_WORD_OFS, C_TRIPLE_B:  return 3;
      C_NO_DELTA:                          return 4;
      default:                             return 1;
    endcase
  endfunction

  // Bytes in a whole record: code, optional delta, payload
  function automatic int total_len(input logic [4:0] code);
    return 1 + ((code == C_NO_DELTA) ? 0 : 2) + record_len(code);
  endfunction

  task automatic restart_stream();
    phase_q       = EXPECT_CODE;
    pay_idx_q     = '0;
    halted_q      = 1'b0;
    stream_open_q = 1'b0;
  endtask

  task automatic expect_error();
    erp_out_t ev;
    ev             = '0;
    ev.parse_error = 1'b1;
    ev.last_result = 1'b1;
    expected_events.insert(expected_events.size(), ev);
  endtask

  // Build the one or two events of the record just completed
  task automatic emit_events();
    erp_out_t first;
    erp_out_t second;
    logic     two;
    first             = '0;
    second            = '0;
    two               = 1'b0;
    first.event_kind  = code_q;
    first.event_time  = clock_q;
    second.event_time = clock_q;
    case (code_q)
      C_DUAL_PRESS: begin
        first.value_a      = {8'h00, payload_q[0]};
        first.value_b      = payload_q[1];
        first.value_count  = 2'd2;
        two                = 1'b1;
        second.event_kind  = KIND_PRESS2;
        second.value_a     = {8'h00, payload_q[1]};
        second.value_count = 2'd1;
      end
      C_APNEA_A, C_APNEA_B, C_APNEA_C, C_APNEA_D, C_APNEA_E: begin
        // offset byte pulls the event back in time; no values
        first.event_time = clock_q - {24'h0, payload_q[0]};
      end
      C_PAIR: begin
        first.value_a     = {8'h00, payload_q[0]};
        first.value_b     = payload_q[1];
        first.value_count = 2'd2;
      end
      C_BARE: ;
      C_TRIPLE_A, C_TRIPLE_B: begin
        first.value_a     = {8'h00, payload_q[0]};
        first.value_b     = payload_q[1];
        first.value_c     = {8'h00, payload_q[2]};
        first.value_count = 2'd3;
      end
      C_WORD_OFS: begin
        first.event_time  = clock_q - {24'h0, payload_q[2]};
        first.value_a     = {payload_q[1], payload_q[0]};
        first.value_b     = payload_q[2];
        first.value_count = 2'd2;
      end
      C_DUAL_LEAK: begin
        first.value_a     = {8'h00, payload_q[0]};
        first.value_count = 2'd1;
        // second leak event only for a nonzero second byte
        if (payload_q[1] != 8'h00) begin
          two                = 1'b1;
          second.event_kind  = KIND_SNORE2;
          second.value_a     = {8'h00, payload_q[1]};
          second.value_count = 2'd1;
        end
      end
      C_NO_DELTA: begin
        first.value_a     = {8'h00, payload_q[0]};
        first.value_b     = payload_q[1];
        first.value_c     = {payload_q[3], payload_q[2]};
        first.value_count = 2'd3;
      end
      default: begin
        first.value_a     = {8'h00, payload_q[0]};
        first.value_count = 2'd1;
      end
    endcase
    first.last_result = !two;
    expected_events.insert(expected_events.size(), first);
    if (two) begin
      second.last_result = 1'b1;
      expected_events.insert(expected_events.size(), second);
    end
  endtask

  // Advance the model by one transferred byte and queue what it causes
  task automatic parse_byte(input erp_in_t item);
    logic [7:0]  b;
    logic [31:0] delta;
    logic        done;
    b    = item.data_byte;
    done = 1'b0;
    if (!stream_open_q) begin
      clock_q       = base_time_q;
      stream_open_q = 1'b1;
    end
    // after an unknown code, drop everything up to the last byte
    if (halted_q) begin
      if (item.last_byte)
        restart_stream();
      return;
    end
    case (phase_q)
      EXPECT_CODE: begin
        if (b > C_MAX_CODE || b == C_RSVD_A || b == C_RSVD_B) begin
          expect_error();
          if (item.last_byte)
            restart_stream();
          else
            halted_q = 1'b1;
          return;
        end
        code_q    = b[4:0];
        pay_idx_q = '0;
        phase_q   = (b[4:0] == C_NO_DELTA) ? EXPECT_PAYLOAD : EXPECT_DELTA_LO;
      end
      EXPECT_DELTA_LO: begin
        delta_lo_q = b;
        phase_q    = EXPECT_DELTA_HI;
      end
      EXPECT_DELTA_HI: begin
        // signed little-endian delta, applied even if the record is cut later
        delta   = {{16{b[7]}}, b, delta_lo_q};
        clock_q = clock_q + delta;
        phase_q = EXPECT_PAYLOAD;
        if (record_len(code_q) == 0)
          done = 1'b1;
      end
      default: begin
        payload_q[pay_idx_q[1:0]] = b;
        pay_idx_q = pay_idx_q + 3'd1;
        if (int'(pay_idx_q) >= record_len(code_q))
          done = 1'b1;
      end
    endcase
    if (done) begin
      emit_events();
      phase_q   = EXPECT_CODE;
      pay_idx_q = '0;
      if (item.last_byte)
        restart_stream();
    end else if (item.last_byte) begin
      // record cut short by the end of the stream
      expect_error();
      restart_stream();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    errors++;
  endtask

  task automatic check_event(input erp_out_t got);
    erp_out_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind)
      report_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
    if (got.event_time !== want.event_time)
      report_field("event_time", want.event_time, got.event_time);
    if (got.value_a !== want.value_a)
      report_field("value_a", 32'(want.value_a), 32'(got.value_a));
    if (got.value_b !== want.value_b)
      report_field("value_b", 32'(want.value_b), 32'(got.value_b));
    if (got.value_c !== want.value_c)
      report_field("value_c", 32'(want.value_c), 32'(got.value_c));
    if (got.value_count !== want.value_count)
      report_field("value_count", 32'(want.value_count), 32'(got.value_count));
    if (got.parse_error !== want.parse_error)
      report_field("parse_error", 32'(want.parse_error), 32'(got.parse_error));
    if (got.last_result !== want.last_result)
      report_field("last_result", 32'(want.last_result), 32'(got.last_result));
  endtask

  // Monitor: sample both channels at the edge; predict on every input
  // transfer, check every output transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        parse_byte(in_data);
      if (out_valid && !out_stall)
        check_event(out_data);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Hold the
  // payload while stalled; move on only once the current transfer is done.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    int      burst_left;
    int      gap_left;
    logic    next_valid;
    erp_in_t next_data;
    if (rst) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || !in_stall) begin
      next_valid = 1'b0;
      next_data  = in_data;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        next_valid = 1'b1;
        next_data  = pending_bytes.pop_front();
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          // pick the next burst and the gap in front of it
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // Receiver: switch among stall patterns in windows of random length
  always @(posedge clk) begin : stall_proc
    int       stall_mode;
    int       mode_left;
    logic [7:0] cyc;
    logic     stall_now;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      cyc        = '0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      cyc++;
      case (stall_mode)
        0:       stall_now = 1'b0;                          // free flow
        1:       stall_now = ($urandom_range(0, 3) == 0);   // light
        2:       stall_now = ($urandom_range(0, 3) != 0);   // heavy
        default: stall_now = (cyc[2:1] == 2'b11);           // periodic
      endcase
      out_stall <= stall_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h00;
      2:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4: return 16'($urandom);
      5, 6: return 16'h0000 - 16'($urandom_range(1, 600));
      default: return 16'($urandom_range(0, 600));
    endcase
  endfunction

  function automatic logic [4:0] rand_code();
    int c;
    c = $urandom_range(0, 16);
    if (c >= 8)
      c += 2;   // skip the two reserved codes
    return 5'(c);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    erp_in_t item;
    item.data_byte = b;
    item.last_byte = last;
    pending_bytes.insert(pending_bytes.size(), item);
    bytes_queued++;
  endtask

  // Queue one record; cut > 0 keeps only the first cut bytes
  task automatic queue_record(input logic [4:0] code, input int cut,
                              input logic ends_stream);
    logic [7:0]  rec [$];
    logic [15:0] delta;
    int          n;
    int          i;
    rec.insert(rec.size(), {3'b000, code});
    if (code != C_NO_DELTA) begin
      delta = rand_delta();
      rec.insert(rec.size(), delta[7:0]);
      rec.insert(rec.size(), delta[15:8]);
    end
    for (i = 0; i < record_len(code); i++)
      rec.insert(rec.size(), rand_byte());
    n = (cut > 0) ? cut : rec.size();
    for (i = 0; i < n; i++)
      queue_byte(rec[i], ends_stream && (i == n - 1));
  endtask

  // One stream: mostly well-formed records, sometimes ending in a cut
  // record or in an unknown code followed by ignored noise.
  task automatic queue_stream();
    int         nrec;
    int         shape;
    int         noise;
    int         i;
    logic [4:0] code;
    logic [7:0] bad;
    erp_in_t    junk;
    nrec  = $urandom_range(1, 6);
    shape = $urandom_range(0, 9);
    for (i = 0; i < nrec - 1; i++)
      queue_record(rand_code(), 0, 1'b0);
    code = rand_code();
    case (shape)
      7: queue_record(code, $urandom_range(1, total_len(code) - 1), 1'b1);
      8: begin
        bad   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? C_RSVD_A : C_RSVD_B)
                                            : 8'($urandom_range(19, 255));
        noise = $urandom_range(0, 5);
        queue_byte(bad, noise == 0);
        // the parser drops these, so keep them out of the item count
        for (i = 0; i < noise; i++) begin
          junk.data_byte = 8'($urandom_range(0, 255));
          junk.last_byte = (i == noise - 1);
          pending_bytes.insert(pending_bytes.size(), junk);
        end
      end
      default: queue_record(code, 0, 1'b1);
    endcase
  endtask

  // Wait for the pipe to drain, then let the tail of the latency pass
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    base_time_q = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int          p;
    int          target;
    logic [31:0] base;
    base_time_q = '0;
    code_q      = '0;
    delta_lo_q  = '0;
    clock_q     = '0;
    foreach (payload_q[i])
      payload_q[i] = '0;
    restart_stream();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_base(32'h0000_1000);
    foreach (DIRECTED[i])
      pending_bytes.insert(pending_bytes.size(), DIRECTED[i]);
    wait_idle();

    // Random phases, each under its own base time; the last one is random
    for (p = 0; p < 5; p++) begin
      base = (p < 4) ? BASE_SETTINGS[p] : $urandom;
      write_base(base);
      target = bytes_queued + ITEMS_PER_PHASE;
      while (bytes_queued < target)
        queue_stream();
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (expected_events.size() != 0) begin
      $display("%0t: %0d expected events never arrived, next expected %h",
               $time, expected_events.size(), expected_events[0]);
      errors++;
    end
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin : watchdog
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ event_record_stream_parser.f @@
rtl/erp_pkg.sv
rtl/erp_parse.sv
rtl/erp_outq.sv
rtl/event_record_stream_parser.sv
bench/tb_top.sv
